// ----- design/skvt_pkg.sv -----
package skvt_pkg;

	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	localparam int OP_BITS     = 3;
	localparam int STATUS_BITS = 2;

	typedef enum logic [OP_BITS-1:0] {
		OP_INSERT  = 3'd0,
		OP_DELETE  = 3'd1,
		OP_LOOKUP  = 3'd2,
		OP_REWIND  = 3'd3,
		OP_ADVANCE = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE    = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_HOLD  = 3'd0,
		CMD_LEFT  = 3'd1,
		CMD_RIGHT = 3'd2,
		CMD_NEW   = 3'd3,
		CMD_VAL   = 3'd4
	} cell_cmd_t;

	typedef struct packed {
		logic      cmp_en;
		logic      active;
		cell_cmd_t cmd;
	} cell_ctl_t;

endpackage

// ----- design/sorted_key_value_table.sv -----
// Sorted key/value table: up to CAPACITY pairs held in a row of cells in ascending
// unsigned key order. Every cell compares its key to the probe in parallel; the
// lowest position whose key is not below the probe is then encoded from that
// thermometer, and insert or delete moves the cells above it one place at once in
// the update state. A word is taken in the idle state and passes through the
// compare, locate, update and output states, the output state registering the
// result and the cursor read. A new word is taken once the previous one has
// reached the output register; a result left waiting there holds the next word at
// its last stage. Missing keys and a cursor at the end read as zero.
module sorted_key_value_table #(
	parameter int CAPACITY   = skvt_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = skvt_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = skvt_pkg::DEF_VALUE_BITS,
	parameter int CW         = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [skvt_pkg::OP_BITS-1:0]  operation,
	input  logic [KEY_BITS-1:0]           key,
	input  logic [VALUE_BITS-1:0]         value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [skvt_pkg::STATUS_BITS-1:0] status,
	output logic                          found,
	output logic [CW-1:0]                 position,
	output logic [VALUE_BITS-1:0]         read_value,
	output logic [CW-1:0]                 entry_count,
	output logic                          cursor_at_end,
	output logic [KEY_BITS-1:0]           cursor_key,
	output logic [VALUE_BITS-1:0]         cursor_value
);
	import skvt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CMP  = 5'b00010,
		S_RES  = 5'b00100,
		S_UPD  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	op_t                   op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         cursor_q;
	status_t               status_q;

	logic [KEY_BITS-1:0]   cell_key [CAPACITY];
	logic [VALUE_BITS-1:0] cell_val [CAPACITY];
	logic [CAPACITY-1:0]   lt_s1;
	logic [CAPACITY-1:0]   eq_s1;
	cell_ctl_t             ctl [CAPACITY];

	logic [CAPACITY:0]     bnd;
	logic [CW-1:0]         pos;
	logic                  hit;
	logic [VALUE_BITS-1:0] rd;

	logic [CAPACITY:0]     bnd_s2;
	logic [CW-1:0]         pos_s2;
	logic                  hit_s2;
	logic [VALUE_BITS-1:0] rd_s2;

	logic                  full;
	logic                  keyed;
	logic                  at_end;
	logic [KEY_BITS-1:0]   cur_key;
	logic [VALUE_BITS-1:0] cur_val;

	assign in_ready = (state_q == S_IDLE);
	assign full     = (count_q == CW'(CAPACITY));
	assign keyed    = (op_q == OP_INSERT) || (op_q == OP_DELETE) || (op_q == OP_LOOKUP);

	// per-cell move command, applied in the update cycle
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctl[i].cmp_en = (state_q == S_CMP);
			ctl[i].active = (CW'(i) < count_q);
			ctl[i].cmd    = CMD_HOLD;
			if (state_q == S_UPD) begin
				case (op_q)
					OP_INSERT: begin
						if (hit_s2)
							ctl[i].cmd = bnd_s2[i] ? CMD_VAL : CMD_HOLD;
						else if (!full)
							ctl[i].cmd = bnd_s2[i] ? CMD_NEW
								: (lt_s1[i] ? CMD_HOLD : CMD_LEFT);
					end
					OP_DELETE: begin
						if (hit_s2)
							ctl[i].cmd = lt_s1[i] ? CMD_HOLD : CMD_RIGHT;
					end
					default: ctl[i].cmd = CMD_HOLD;
				endcase
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		skvt_cell #(
			.KEY_BITS  (KEY_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl[g]),
			.probe_key  (key_q),
			.new_value  (value_q),
			.left_key   ((g == 0) ? key_q : cell_key[(g == 0) ? 0 : g - 1]),
			.left_value ((g == 0) ? value_q : cell_val[(g == 0) ? 0 : g - 1]),
			.right_key  (cell_key[(g == CAPACITY - 1) ? g : g + 1]),
			.right_value(cell_val[(g == CAPACITY - 1) ? g : g + 1]),
			.cell_key   (cell_key[g]),
			.cell_value (cell_val[g]),
			.lt_s1      (lt_s1[g]),
			.eq_s1      (eq_s1[g])
		);
	end

	skvt_locate #(
		.CAPACITY(CAPACITY),
		.PW      (CW)
	) u_locate (
		.lt (lt_s1),
		.eq (eq_s1),
		.bnd(bnd),
		.pos(pos),
		.hit(hit)
	);

	always_comb begin
		rd = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (bnd[i] && eq_s1[i])
				rd = rd | cell_val[i];
		end
	end

	always_comb begin
		at_end  = (cursor_q >= count_q);
		cur_key = '0;
		cur_val = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!at_end && cursor_q == CW'(i)) begin
				cur_key = cur_key | cell_key[i];
				cur_val = cur_val | cell_val[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q    <= op_t'(operation);
			key_q   <= key;
			value_q <= value;
		end
		if (state_q == S_RES) begin
			bnd_s2 <= bnd;
			pos_s2 <= pos;
			hit_s2 <= hit;
			rd_s2  <= rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cursor_q  <= '0;
			status_q  <= ST_DONE;
			out_valid <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CMP;
				S_CMP:  state_q <= S_RES;
				S_RES:  state_q <= S_UPD;
				S_UPD: begin
					case (op_q)
						OP_INSERT: begin
							if (hit_s2) begin
								status_q <= ST_DONE;
								cursor_q <= pos_s2;
							end else if (full) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_DONE;
								count_q  <= count_q + 1'b1;
								cursor_q <= pos_s2;
							end
						end
						OP_DELETE: begin
							if (hit_s2) begin
								status_q <= ST_DONE;
								count_q  <= count_q - 1'b1;
								cursor_q <= pos_s2;
							end else begin
								status_q <= ST_MISSING;
							end
						end
						OP_LOOKUP: status_q <= hit_s2 ? ST_DONE : ST_MISSING;
						OP_REWIND: begin
							status_q <= ST_DONE;
							cursor_q <= '0;
						end
						OP_ADVANCE: begin
							status_q <= ST_DONE;
							if (cursor_q < count_q) cursor_q <= cursor_q + 1'b1;
						end
						default: status_q <= ST_DONE;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the previous result has been taken
					if (!out_valid || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid || out_ready)) begin
			status        <= status_q;
			found         <= keyed && hit_s2;
			position      <= keyed ? pos_s2 : '0;
			read_value    <= (op_q == OP_LOOKUP && hit_s2) ? rd_s2 : '0;
			entry_count   <= count_q;
			cursor_at_end <= at_end;
			cursor_key    <= cur_key;
			cursor_value  <= cur_val;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("pair count above capacity");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("walk cursor beyond pair count");

	a_single_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RES |-> $onehot(bnd))
		else $error("search boundary not unique");

	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside the output stage");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |-> (count_q == $past(count_q)
			|| count_q == $past(count_q) + CW'(1)
			|| count_q == $past(count_q) - CW'(1)))
		else $error("pair count moved by more than one");
`endif

endmodule

// ----- design/skvt_cell.sv -----
module skvt_cell #(
	parameter int KEY_BITS   = skvt_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = skvt_pkg::DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  skvt_pkg::cell_ctl_t   ctl,
	input  logic [KEY_BITS-1:0]   probe_key,
	input  logic [VALUE_BITS-1:0] new_value,
	input  logic [KEY_BITS-1:0]   left_key,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [KEY_BITS-1:0]   right_key,
	input  logic [VALUE_BITS-1:0] right_value,
	output logic [KEY_BITS-1:0]   cell_key,
	output logic [VALUE_BITS-1:0] cell_value,
	output logic                  lt_s1,
	output logic                  eq_s1
);
	import skvt_pkg::*;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			lt_s1 <= ctl.active && (key_q < probe_key);
			eq_s1 <= ctl.active && (key_q == probe_key);
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_LEFT: begin
				key_q   <= left_key;
				value_q <= left_value;
			end
			CMD_RIGHT: begin
				key_q   <= right_key;
				value_q <= right_value;
			end
			CMD_NEW: begin
				key_q   <= probe_key;
				value_q <= new_value;
			end
			CMD_VAL: value_q <= new_value;
			default: begin
				key_q   <= key_q;
				value_q <= value_q;
			end
		endcase
	end

	assign cell_key   = key_q;
	assign cell_value = value_q;

endmodule

// ----- design/skvt_locate.sv -----
module skvt_locate #(
	parameter int CAPACITY = skvt_pkg::DEF_CAPACITY,
	parameter int PW       = $clog2(CAPACITY + 1)
) (
	input  logic [CAPACITY-1:0] lt,
	input  logic [CAPACITY-1:0] eq,
	output logic [CAPACITY:0]   bnd,
	output logic [PW-1:0]       pos,
	output logic                hit
);
	import skvt_pkg::*;

	// lt is a thermometer over the sorted cells; mark the first cell that is not below
	always_comb begin
		bnd = '0;
		pos = '0;
		hit = 1'b0;
		for (int i = 0; i <= CAPACITY; i++) begin
			bnd[i] = ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i - 1])
				& ((i == CAPACITY) ? 1'b1 : ~lt[(i == CAPACITY) ? 0 : i]);
		end
		for (int i = 0; i <= CAPACITY; i++) begin
			if (bnd[i])
				pos = pos | PW'(i);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			hit = hit | (bnd[i] & eq[i]);
		end
	end

endmodule
